>>> rtl/core/fmd_pkg.sv
package fmd_pkg;

   // Framing constants.
   localparam logic [7:0]  FRAME_MARK   = 8'h2a;
   localparam logic [7:0]  CHAN_DATA    = 8'd2;
   localparam logic [7:0]  CHAN_SIGNOFF = 8'd4;
   localparam logic [15:0] MSG_HDR_LEN  = 16'd10;
   localparam logic [15:0] EXT_LEN_SIZE = 16'd2;
   localparam int          EXT_FLAG_BIT = 15;

   // Positions within the frame header and the message header.
   localparam logic [3:0] FHD_CHAN_IDX   = 4'd1;
   localparam logic [3:0] FHD_LEN_HI_IDX = 4'd4;
   localparam logic [3:0] FHD_LEN_LO_IDX = 4'd5;
   localparam logic [3:0] MHD_WORD_BYTES = 4'd6;
   localparam logic [3:0] MHD_LAST_IDX   = 4'd9;
   localparam logic [3:0] EXT_LAST_IDX   = 4'd1;

   // Result queue between the parser and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_RESYNC  = 3'd1,
      PH_FRAMEHD = 3'd2,
      PH_SKIP    = 3'd3,
      PH_MSGHD   = 3'd4,
      PH_EXTLEN  = 3'd5,
      PH_EXTSKIP = 3'd6,
      PH_BODY    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_BODY      = 3'd0,
      EV_EMPTY     = 3'd1,
      EV_SIGNOFF   = 3'd2,
      EV_BAD_MARK  = 3'd3,
      EV_SHORT_HDR = 3'd4,
      EV_SHORT_EXT = 3'd5
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    family;
      logic [15:0]    subtype;
      logic [15:0]    flags;
      logic [31:0]    ident;
      logic [7:0]     body;
      logic           last;
   } result_type;

endpackage

>>> rtl/core/fmd_parse.sv
module fmd_parse
   import fmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_accept,
   input  logic [7:0] byte_data,
   output logic       result_push,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  index_ff, index_in;
   logic [7:0]  channel_ff, channel_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] ext_ff, ext_in;
   logic [47:0] header_ff, header_in;
   logic [31:0] request_ff, request_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         index_ff     <= '0;
         channel_ff   <= '0;
         remaining_ff <= '0;
         ext_ff       <= '0;
         header_ff    <= '0;
         request_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         channel_ff   <= channel_in;
         remaining_ff <= remaining_in;
         ext_ff       <= ext_in;
         header_ff    <= header_in;
         request_ff   <= request_in;
      end
   end

   logic           start_body;
   logic           frame_err;
   logic           with_hdr;
   event_kind_type kind;

   always_comb begin
      phase_in     = phase_ff;
      index_in     = index_ff;
      channel_in   = channel_ff;
      remaining_in = remaining_ff;
      ext_in       = ext_ff;
      header_in    = header_ff;
      request_in   = request_ff;
      start_body   = 1'b0;
      frame_err    = 1'b0;
      with_hdr     = 1'b0;
      kind         = EV_BODY;
      result_push  = 1'b0;
      result.body  = '0;
      result.last  = 1'b1;

      if (byte_accept) begin
         case (phase_ff)
            PH_FRAMEHD: begin
               if (index_ff == FHD_CHAN_IDX) begin
                  channel_in = byte_data;
               end else if (index_ff == FHD_LEN_HI_IDX) begin
                  remaining_in = {byte_data, 8'h00};
               end else if (index_ff == FHD_LEN_LO_IDX) begin
                  remaining_in = {remaining_ff[15:8], byte_data};
               end
               if (index_ff < FHD_LEN_LO_IDX) begin
                  index_in = index_ff + 4'd1;
               end else begin
                  index_in = '0;
                  if (channel_ff == CHAN_DATA) begin
                     if (remaining_in < MSG_HDR_LEN) begin
                        frame_err = 1'b1;
                        kind      = EV_SHORT_HDR;
                     end else begin
                        phase_in = PH_MSGHD;
                     end
                  end else if (remaining_in == 16'd0) begin
                     phase_in = PH_HUNT;
                     if (channel_ff == CHAN_SIGNOFF) begin
                        result_push = 1'b1;
                        kind        = EV_SIGNOFF;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               remaining_in = remaining_ff - 16'd1;
               if (remaining_in == 16'd0) begin
                  phase_in = PH_HUNT;
                  if (channel_ff == CHAN_SIGNOFF) begin
                     result_push = 1'b1;
                     kind        = EV_SIGNOFF;
                  end
               end
            end
            PH_MSGHD: begin
               if (index_ff < MHD_WORD_BYTES) begin
                  header_in = {header_ff[39:0], byte_data};
               end else begin
                  request_in = {request_ff[23:0], byte_data};
               end
               remaining_in = remaining_ff - 16'd1;
               index_in     = index_ff + 4'd1;
               if (index_ff == MHD_LAST_IDX) begin
                  index_in = '0;
                  if (header_in[EXT_FLAG_BIT]) begin
                     if (remaining_in < EXT_LEN_SIZE) begin
                        frame_err = 1'b1;
                        with_hdr  = 1'b1;
                        kind      = EV_SHORT_EXT;
                     end else begin
                        phase_in = PH_EXTLEN;
                     end
                  end else begin
                     start_body = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               ext_in       = {ext_ff[7:0], byte_data};
               remaining_in = remaining_ff - 16'd1;
               index_in     = index_ff + 4'd1;
               if (index_ff == EXT_LAST_IDX) begin
                  index_in = '0;
                  if (ext_in > remaining_in) begin
                     frame_err = 1'b1;
                     with_hdr  = 1'b1;
                     kind      = EV_SHORT_EXT;
                  end else if (ext_in == 16'd0) begin
                     start_body = 1'b1;
                  end else begin
                     phase_in = PH_EXTSKIP;
                  end
               end
            end
            PH_EXTSKIP: begin
               ext_in       = ext_ff - 16'd1;
               remaining_in = remaining_ff - 16'd1;
               if (ext_in == 16'd0) begin
                  start_body = 1'b1;
               end
            end
            PH_BODY: begin
               remaining_in = remaining_ff - 16'd1;
               if (remaining_in == 16'd0) begin
                  phase_in = PH_HUNT;
               end
               result_push = 1'b1;
               with_hdr    = 1'b1;
               kind        = EV_BODY;
               result.body = byte_data;
               result.last = (remaining_in == 16'd0);
            end
            default: begin
               if (byte_data == FRAME_MARK) begin
                  phase_in = PH_FRAMEHD;
                  index_in = FHD_CHAN_IDX;
               end else if (phase_ff == PH_HUNT) begin
                  phase_in    = PH_RESYNC;
                  result_push = 1'b1;
                  kind        = EV_BAD_MARK;
               end
            end
         endcase

         // An error drops the rest of the frame, if any is left.
         if (frame_err) begin
            result_push = 1'b1;
            phase_in    = (remaining_in != 16'd0) ? PH_SKIP : PH_HUNT;
         end

         // After the header and any extension: an empty body is reported at once.
         if (start_body) begin
            if (remaining_in == 16'd0) begin
               phase_in    = PH_HUNT;
               result_push = 1'b1;
               with_hdr    = 1'b1;
               kind        = EV_EMPTY;
            end else begin
               phase_in = PH_BODY;
            end
         end
      end

      result.kind    = kind;
      result.family  = with_hdr ? header_in[47:32] : 16'd0;
      result.subtype = with_hdr ? header_in[31:16] : 16'd0;
      result.flags   = with_hdr ? header_in[15:0]  : 16'd0;
      result.ident   = with_hdr ? request_in       : 32'd0;
   end

endmodule

>>> rtl/core/fmd_queue.sv
module fmd_queue
   import fmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop,
   output result_type pop_data,
   output logic       full,
   output logic       empty
);

   result_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/fmd_out.sv
module fmd_out
   import fmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  result_type queue_data,
   output logic       queue_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Refill the output register whenever it is empty or being taken.
   assign queue_pop = !queue_empty && (!valid_ff || out_ready);
   assign valid_in  = queue_pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         data_ff <= queue_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/framed_message_deframer_core.sv
// Channel  Direction  Handshake              Contents
// req      in         req_valid/req_ready    one received stream byte per item
// rsp      out        rsp_valid/rsp_ready    one event per item, with message header if parsed
//
// One byte is accepted every clock while req_ready is high; an item yields at most one result.
// A result passes through the result queue and then the output register before it appears on rsp.
// Reset is synchronous and active high; the parser returns to hunting for a marker.
// A four-entry result queue sits between the parser and the output register,
// so req_ready only falls when the rsp side has stalled long enough to fill it.
module framed_message_deframer_core
   import fmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [15:0] rsp_msg_family,
   output logic [15:0] rsp_msg_subtype,
   output logic [15:0] rsp_msg_flags,
   output logic [31:0] rsp_request_ident,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_last_of_body
);

   logic       byte_accept;
   logic       result_push;
   result_type result;
   logic       queue_full;
   logic       queue_empty;
   logic       queue_pop;
   result_type queue_data;
   result_type out_data;

   // The parser never produces more than one result per byte, so a free
   // queue slot is all it takes to accept the next byte.
   assign req_ready   = !queue_full;
   assign byte_accept = req_valid && req_ready;

   // Front: frame and message header parsing, one byte per cycle while req_ready is high.
   fmd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_data   (req_rx_byte),
      .result_push (result_push),
      .result      (result)
   );

   // Decoupling queue between the parser and the result channel.
   fmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // Back: registered result channel.
   fmd_out u_out (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .queue_pop   (queue_pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (out_data)
   );

   assign rsp_event_kind    = out_data.kind;
   assign rsp_msg_family    = out_data.family;
   assign rsp_msg_subtype   = out_data.subtype;
   assign rsp_msg_flags     = out_data.flags;
   assign rsp_request_ident = out_data.ident;
   assign rsp_body_byte     = out_data.body;
   assign rsp_last_of_body  = out_data.last;

endmodule
